@@ sv/bra_pkg.sv @@
// Shared constants and types for the box region average block.
package bra_pkg;

	// Frame geometry limits and pixel store shape
	localparam int MAX_WIDTH   = 128;
	localparam int MAX_HEIGHT  = 128;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	// Channel layout of one stored pixel word
	localparam int CHANNELS = 4;
	localparam int CHAN_W   = 8;
	localparam int PIXEL_W  = CHANNELS * CHAN_W;

	// Field widths
	localparam int COORD_W = 16;
	localparam int FRAME_W = 8;
	localparam int XW      = $clog2(MAX_WIDTH);
	localparam int YW      = $clog2(MAX_HEIGHT);

	// Accumulator and pixel count widths for a full-frame rectangle
	localparam int SUM_W = $clog2(STORE_DEPTH * ((1 << CHAN_W) - 1) + 1);
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);

	// Configuration register indexes
	localparam logic CFG_FRAME_WIDTH  = 1'b0;
	localparam logic CFG_FRAME_HEIGHT = 1'b1;

	// Input item modes
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Query sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SUM,
		ST_DRAIN,
		ST_LAUNCH,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	typedef logic [CHANNELS-1:0][SUM_W-1:0]  sums_t;
	typedef logic [CHANNELS-1:0][CHAN_W-1:0] chans_t;

endpackage

@@ sv/bra_pixel_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with registered read data.
module bra_pixel_ram #(
	parameter int DEPTH = 16384,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ sv/bra_divider.sv @@
// Four-lane restoring divider producing 8-bit truncated channel means.
module bra_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  bra_pkg::sums_t             dividend,
	input  logic [bra_pkg::CNT_W-1:0]  divisor,
	output logic                       done,
	output bra_pkg::chans_t            quotient
);

	localparam int BIT_W = $clog2(bra_pkg::CHAN_W);

	bra_pkg::sums_t                rem_q;
	logic [bra_pkg::SUM_W-1:0]     div_q;
	logic [BIT_W-1:0]              bit_q;
	logic                          busy_q;
	logic                          done_q;

	// Control: walk quotient bits from the top down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= BIT_W'(bra_pkg::CHAN_W - 1);
			end else if (busy_q) begin
				bit_q <= bit_q - 1'b1;
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: trial subtract of the shifted divisor in every lane
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q    <= dividend;
			quotient <= '0;
			div_q    <= bra_pkg::SUM_W'({divisor, (bra_pkg::CHAN_W - 1)'(0)});
		end else if (busy_q) begin
			for (int c = 0; c < bra_pkg::CHANNELS; c++) begin
				if (rem_q[c] >= div_q) begin
					rem_q[c]           <= rem_q[c] - div_q;
					quotient[c][bit_q] <= 1'b1;
				end
			end
			div_q <= div_q >> 1;
		end
	end

	assign done = done_q;

endmodule

@@ sv/box_region_average.sv @@
// Top level: pixel store loading and rectangle average sequencer.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------------
//   in      | sink      | in_valid/in_stall  | mode, pixel_*, corner_*
//   out     | source    | out_valid/out_stall| average_red/green/blue/alpha
//   cfg     | sink      | cfg_valid/cfg_ready| cfg_index (0 width, 1 height), cfg_data
//
// A write beat leaves the sequencer idle. A query inside the frame passes through
// setup, one store read per pixel, drain, launch, the divider (eight quotient bits,
// then done) and the output load before the next beat. A query outside the frame
// goes from setup straight to the output load. No clearing pass follows reset; the frame
// registers reset to 128 x 128. A stalled result holds in the output register while
// the next beat is accepted; a query then waits at its end until the result is taken.
module box_region_average (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_index,
	input  logic [bra_pkg::FRAME_W-1:0]          cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 mode,
	input  logic [bra_pkg::ADDR_W-1:0]           pixel_address,
	input  logic [bra_pkg::CHAN_W-1:0]           pixel_red,
	input  logic [bra_pkg::CHAN_W-1:0]           pixel_green,
	input  logic [bra_pkg::CHAN_W-1:0]           pixel_blue,
	input  logic [bra_pkg::CHAN_W-1:0]           pixel_alpha,
	input  logic signed [bra_pkg::COORD_W-1:0]   corner_x0,
	input  logic signed [bra_pkg::COORD_W-1:0]   corner_y0,
	input  logic signed [bra_pkg::COORD_W-1:0]   corner_x1,
	input  logic signed [bra_pkg::COORD_W-1:0]   corner_y1,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [bra_pkg::CHAN_W-1:0]           average_red,
	output logic [bra_pkg::CHAN_W-1:0]           average_green,
	output logic [bra_pkg::CHAN_W-1:0]           average_blue,
	output logic [bra_pkg::CHAN_W-1:0]           average_alpha
);

	localparam int CW = bra_pkg::COORD_W;
	localparam int FW = bra_pkg::FRAME_W;

	bra_pkg::state_t state_q, state_d;

	logic [FW-1:0]              frame_width_q, frame_height_q;
	logic [FW-1:0]              w_lim, h_lim;
	logic                       in_acc, cfg_acc;
	logic                       div_start, div_done, out_load;

	logic signed [CW-1:0]       xlo, xhi, ylo, yhi, w_s, h_s;
	logic signed [CW-1:0]       xhi_c, yhi_c;
	logic                       outside;

	logic [bra_pkg::XW-1:0]     x0_q, x1_q, x_q;
	logic [bra_pkg::YW-1:0]     y0_q, y1_q, y_q;
	logic                       empty_q;
	logic [FW-1:0]              w_q;
	logic [bra_pkg::ADDR_W-1:0] row_base_q;
	logic [bra_pkg::ADDR_W-1:0] rd_addr;
	logic [bra_pkg::CNT_W-1:0]  count_q;
	logic                       rd_vld_s1;
	bra_pkg::sums_t             sum_q;
	bra_pkg::chans_t            quot;
	logic [bra_pkg::PIXEL_W-1:0] rd_data;
	logic                       wr_en;
	logic                       out_valid_q;
	bra_pkg::chans_t            avg_q;

	assign in_acc    = in_valid && !in_stall;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != bra_pkg::ST_IDLE);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW'(128);
			frame_height_q <= FW'(128);
		end else if (cfg_acc) begin
			unique case (cfg_index)
				bra_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				bra_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Saturate the frame size to the store limits
	assign w_lim = ({1'b0, frame_width_q} > (FW + 1)'(bra_pkg::MAX_WIDTH))
		? FW'(bra_pkg::MAX_WIDTH) : frame_width_q;
	assign h_lim = ({1'b0, frame_height_q} > (FW + 1)'(bra_pkg::MAX_HEIGHT))
		? FW'(bra_pkg::MAX_HEIGHT) : frame_height_q;

	// Order corners, test against the frame, clamp the far corners
	always_comb begin
		w_s     = $signed({(CW - FW)'(0), w_lim});
		h_s     = $signed({(CW - FW)'(0), h_lim});
		xlo     = (corner_x1 < corner_x0) ? corner_x1 : corner_x0;
		xhi     = (corner_x1 < corner_x0) ? corner_x0 : corner_x1;
		ylo     = (corner_y1 < corner_y0) ? corner_y1 : corner_y0;
		yhi     = (corner_y1 < corner_y0) ? corner_y0 : corner_y1;
		outside = (w_lim == '0) || (h_lim == '0) || (xhi < 0) || (xlo >= w_s)
			|| (yhi < 0) || (ylo >= h_s);
		xhi_c   = (xhi >= w_s) ? (w_s - CW'(1)) : xhi;
		yhi_c   = (yhi >= h_s) ? (h_s - CW'(1)) : yhi;
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bra_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state and strobes
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			bra_pkg::ST_IDLE: begin
				if (in_acc && mode == bra_pkg::MODE_QUERY) state_d = bra_pkg::ST_SETUP;
			end
			bra_pkg::ST_SETUP: begin
				state_d = empty_q ? bra_pkg::ST_EMIT : bra_pkg::ST_SUM;
			end
			bra_pkg::ST_SUM: begin
				if (x_q == x1_q && y_q == y1_q) state_d = bra_pkg::ST_DRAIN;
			end
			bra_pkg::ST_DRAIN: begin
				state_d = bra_pkg::ST_LAUNCH;
			end
			bra_pkg::ST_LAUNCH: begin
				div_start = 1'b1;
				state_d   = bra_pkg::ST_DIVIDE;
			end
			bra_pkg::ST_DIVIDE: begin
				if (div_done) state_d = bra_pkg::ST_EMIT;
			end
			bra_pkg::ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = bra_pkg::ST_IDLE;
				end
			end
			default: state_d = bra_pkg::ST_IDLE;
		endcase
	end

	// Capture the clamped rectangle on a query beat
	always_ff @(posedge clk) begin
		if (in_acc && mode == bra_pkg::MODE_QUERY) begin
			x0_q    <= (xlo < 0) ? '0 : xlo[bra_pkg::XW-1:0];
			y0_q    <= (ylo < 0) ? '0 : ylo[bra_pkg::YW-1:0];
			x1_q    <= xhi_c[bra_pkg::XW-1:0];
			y1_q    <= yhi_c[bra_pkg::YW-1:0];
			empty_q <= outside;
			w_q     <= w_lim;
		end
	end

	// Set up the walk, advance it one pixel per cycle
	always_ff @(posedge clk) begin
		if (state_q == bra_pkg::ST_SETUP) begin
			x_q        <= x0_q;
			y_q        <= y0_q;
			row_base_q <= bra_pkg::ADDR_W'(y0_q) * bra_pkg::ADDR_W'(w_q);
			count_q    <= bra_pkg::CNT_W'((x1_q - x0_q + 1'b1) * (y1_q - y0_q + 1'b1)
				+ (bra_pkg::CNT_W)'(0));
		end else if (state_q == bra_pkg::ST_SUM) begin
			if (x_q == x1_q) begin
				x_q        <= x0_q;
				y_q        <= y_q + 1'b1;
				row_base_q <= row_base_q + bra_pkg::ADDR_W'(w_q);
			end else begin
				x_q <= x_q + 1'b1;
			end
		end
	end

	assign rd_addr = row_base_q + bra_pkg::ADDR_W'(x_q);

	// Track read data returning from the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == bra_pkg::ST_SUM);
		end
	end

	// Accumulate each channel
	always_ff @(posedge clk) begin
		if (state_q == bra_pkg::ST_SETUP) begin
			sum_q <= '0;
		end else if (rd_vld_s1) begin
			for (int c = 0; c < bra_pkg::CHANNELS; c++) begin
				sum_q[c] <= sum_q[c]
					+ bra_pkg::SUM_W'(rd_data[c*bra_pkg::CHAN_W +: bra_pkg::CHAN_W]);
			end
		end
	end

	// Drop writes beyond the store
	assign wr_en = in_acc && (mode == bra_pkg::MODE_WRITE)
		&& ({1'b0, pixel_address} < (bra_pkg::ADDR_W + 1)'(bra_pkg::STORE_DEPTH));

	bra_pixel_ram #(
		.DEPTH (bra_pkg::STORE_DEPTH),
		.WIDTH (bra_pkg::PIXEL_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (pixel_address),
		.wr_data ({pixel_alpha, pixel_blue, pixel_green, pixel_red}),
		.rd_en   (state_q == bra_pkg::ST_SUM),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	bra_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (quot)
	);

	// Output register: hold a stalled beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			avg_q <= empty_q ? '0 : quot;
		end
	end

	assign out_valid     = out_valid_q;
	assign average_red   = avg_q[0];
	assign average_green = avg_q[1];
	assign average_blue  = avg_q[2];
	assign average_alpha = avg_q[3];

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for box_region_average: pixel loads, rectangle queries, frame settings.
module tb_top;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int LONG_HOLD    = 300;
	localparam int BLOCK_MAX    = 3;

	typedef enum int {PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pacing_t;

	// One input beat: a pixel write or a rectangle query
	typedef struct {
		logic                               mode;
		logic [bra_pkg::ADDR_W-1:0]         address;
		logic [bra_pkg::CHAN_W-1:0]         red, green, blue, alpha;
		logic signed [bra_pkg::COORD_W-1:0] x0, y0, x1, y1;
	} beat_t;

	typedef struct {
		logic [bra_pkg::CHAN_W-1:0] red, green, blue, alpha;
	} averages_t;

	// Frame store mirror, average predictor and result checker
	class region_average_scoreboard;
		logic [bra_pkg::PIXEL_W-1:0] pixels [bra_pkg::STORE_DEPTH];
		bit                          written [bra_pkg::STORE_DEPTH];
		int unsigned                 width_reg;
		int unsigned                 height_reg;
		averages_t                   pending_averages [$];
		int                          errors, writes, queries, results;

		function new();
			width_reg  = bra_pkg::MAX_WIDTH;
			height_reg = bra_pkg::MAX_HEIGHT;
		endfunction

		function void set_register(logic index, logic [bra_pkg::FRAME_W-1:0] value);
			if (index == bra_pkg::CFG_FRAME_WIDTH)
				width_reg = value;
			else
				height_reg = value;
		endfunction

		function int frame_cols();
			return (width_reg > bra_pkg::MAX_WIDTH) ? bra_pkg::MAX_WIDTH : width_reg;
		endfunction

		function int frame_rows();
			return (height_reg > bra_pkg::MAX_HEIGHT) ? bra_pkg::MAX_HEIGHT : height_reg;
		endfunction

		// Order the corners and clamp them to the frame; 0 when nothing is covered
		function bit clamp_rect(beat_t b, output int xa, output int ya,
				output int xb, output int yb);
			int cols, rows;
			cols = frame_cols();
			rows = frame_rows();
			xa = (b.x1 < b.x0) ? b.x1 : b.x0;
			xb = (b.x1 < b.x0) ? b.x0 : b.x1;
			ya = (b.y1 < b.y0) ? b.y1 : b.y0;
			yb = (b.y1 < b.y0) ? b.y0 : b.y1;
			if (cols == 0 || rows == 0 || xb < 0 || xa >= cols || yb < 0 || ya >= rows)
				return 1'b0;
			if (xa < 0) xa = 0;
			if (xb >= cols) xb = cols - 1;
			if (ya < 0) ya = 0;
			if (yb >= rows) yb = rows - 1;
			return 1'b1;
		endfunction

		// True when a query would read only pixels loaded since reset
		function bit rect_written(beat_t b);
			int xa, ya, xb, yb;
			if (!clamp_rect(b, xa, ya, xb, yb))
				return 1'b1;
			for (int y = ya; y <= yb; y++)
				for (int x = xa; x <= xb; x++)
					if (!written[y * frame_cols() + x])
						return 1'b0;
			return 1'b1;
		endfunction

		// Apply an accepted beat; a query queues its four averages
		function void note_input(beat_t b);
			int                          xa, ya, xb, yb;
			longint                      sums [bra_pkg::CHANNELS];
			longint                      count;
			logic [bra_pkg::PIXEL_W-1:0] word;
			averages_t                   avg;
			if (b.mode == bra_pkg::MODE_WRITE) begin
				pixels[b.address]  = {b.alpha, b.blue, b.green, b.red};
				written[b.address] = 1'b1;
				writes++;
				return;
			end
			queries++;
			avg = '{default: '0};
			if (clamp_rect(b, xa, ya, xb, yb)) begin
				for (int c = 0; c < bra_pkg::CHANNELS; c++)
					sums[c] = 0;
				for (int y = ya; y <= yb; y++)
					for (int x = xa; x <= xb; x++) begin
						word = pixels[y * frame_cols() + x];
						for (int c = 0; c < bra_pkg::CHANNELS; c++)
							sums[c] += word[c*bra_pkg::CHAN_W +: bra_pkg::CHAN_W];
					end
				count     = longint'(xb - xa + 1) * longint'(yb - ya + 1);
				avg.red   = bra_pkg::CHAN_W'(sums[0] / count);
				avg.green = bra_pkg::CHAN_W'(sums[1] / count);
				avg.blue  = bra_pkg::CHAN_W'(sums[2] / count);
				avg.alpha = bra_pkg::CHAN_W'(sums[3] / count);
			end
			pending_averages.push_back(avg);
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $time, msg);
		endtask

		// Compare one accepted result with the oldest pending averages
		task check_result(averages_t got);
			averages_t want;
			results++;
			if (pending_averages.size() == 0) begin
				report($sformatf("result %0d/%0d/%0d/%0d with no query pending",
					got.red, got.green, got.blue, got.alpha));
				return;
			end
			want = pending_averages.pop_front();
			if (got.red !== want.red)
				report($sformatf("average_red %0d, want %0d", got.red, want.red));
			if (got.green !== want.green)
				report($sformatf("average_green %0d, want %0d", got.green, want.green));
			if (got.blue !== want.blue)
				report($sformatf("average_blue %0d, want %0d", got.blue, want.blue));
			if (got.alpha !== want.alpha)
				report($sformatf("average_alpha %0d, want %0d", got.alpha, want.alpha));
		endtask
	endclass

	logic                               clk           = 1'b0;
	logic                               arst_n        = 1'b0;
	logic                               cfg_valid     = 1'b0;
	logic                               cfg_ready;
	logic                               cfg_index     = bra_pkg::CFG_FRAME_WIDTH;
	logic [bra_pkg::FRAME_W-1:0]        cfg_data      = '0;
	logic                               in_valid      = 1'b0;
	logic                               in_stall;
	logic                               mode          = bra_pkg::MODE_WRITE;
	logic [bra_pkg::ADDR_W-1:0]         pixel_address = '0;
	logic [bra_pkg::CHAN_W-1:0]         pixel_red     = '0;
	logic [bra_pkg::CHAN_W-1:0]         pixel_green   = '0;
	logic [bra_pkg::CHAN_W-1:0]         pixel_blue    = '0;
	logic [bra_pkg::CHAN_W-1:0]         pixel_alpha   = '0;
	logic signed [bra_pkg::COORD_W-1:0] corner_x0     = '0;
	logic signed [bra_pkg::COORD_W-1:0] corner_y0     = '0;
	logic signed [bra_pkg::COORD_W-1:0] corner_x1     = '0;
	logic signed [bra_pkg::COORD_W-1:0] corner_y1     = '0;
	logic                               out_valid;
	logic                               out_stall     = 1'b0;
	logic [bra_pkg::CHAN_W-1:0]         average_red;
	logic [bra_pkg::CHAN_W-1:0]         average_green;
	logic [bra_pkg::CHAN_W-1:0]         average_blue;
	logic [bra_pkg::CHAN_W-1:0]         average_alpha;

	region_average_scoreboard board = new();

	int idle_pct  = 0;
	int stall_pct = 0;
	int hold_kicks = 0;
	int hold_seen  = 0;
	int hold_left  = 0;
	int cycles     = 0;
	int block_cols = 0;
	int block_rows = 0;
	int frame_settings = 1;

	box_region_average u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.pixel_address (pixel_address),
		.pixel_red     (pixel_red),
		.pixel_green   (pixel_green),
		.pixel_blue    (pixel_blue),
		.pixel_alpha   (pixel_alpha),
		.corner_x0     (corner_x0),
		.corner_y0     (corner_y0),
		.corner_x1     (corner_x1),
		.corner_y1     (corner_y1),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.average_red   (average_red),
		.average_green (average_green),
		.average_blue  (average_blue),
		.average_alpha (average_alpha)
	);

	// Free-running clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Stall results at random, or hold off for a long stretch when kicked
	always @(posedge clk) begin
		if (hold_kicks != hold_seen) begin
			hold_seen = hold_kicks;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Check every result beat
	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			board.check_result(averages_t'{average_red, average_green,
				average_blue, average_alpha});

	function automatic beat_t random_fields();
		beat_t b;
		b.mode    = bra_pkg::MODE_WRITE;
		b.address = bra_pkg::ADDR_W'($urandom());
		{b.alpha, b.blue, b.green, b.red} = $urandom();
		b.x0 = bra_pkg::COORD_W'($urandom());
		b.y0 = bra_pkg::COORD_W'($urandom());
		b.x1 = bra_pkg::COORD_W'($urandom());
		b.y1 = bra_pkg::COORD_W'($urandom());
		return b;
	endfunction

	function automatic beat_t make_write(int address, logic [bra_pkg::PIXEL_W-1:0] word);
		beat_t b;
		b = random_fields();
		b.mode    = bra_pkg::MODE_WRITE;
		b.address = bra_pkg::ADDR_W'(address);
		{b.alpha, b.blue, b.green, b.red} = word;
		return b;
	endfunction

	function automatic beat_t make_query(logic signed [bra_pkg::COORD_W-1:0] x0,
			logic signed [bra_pkg::COORD_W-1:0] y0, logic signed [bra_pkg::COORD_W-1:0] x1,
			logic signed [bra_pkg::COORD_W-1:0] y1);
		beat_t b;
		b = random_fields();
		b.mode = bra_pkg::MODE_QUERY;
		b.x0   = x0;
		b.y0   = y0;
		b.x1   = x1;
		b.y1   = y1;
		return b;
	endfunction

	// Mostly near the loaded block, sometimes at the far edge or the extremes
	function automatic logic signed [bra_pkg::COORD_W-1:0] pick_coord(int blk, int dim);
		case ($urandom_range(11))
			0: return bra_pkg::COORD_W'($urandom());
			1: return 16'sh7fff;
			2: return 16'sh8000;
			3: return bra_pkg::COORD_W'(dim - 1 + $urandom_range(2));
			4: return -bra_pkg::COORD_W'($urandom_range(3, 1));
			default: return bra_pkg::COORD_W'($urandom_range(blk));
		endcase
	endfunction

	function automatic beat_t random_item();
		beat_t b;
		int    cols, rows, address;
		cols = board.frame_cols();
		rows = board.frame_rows();
		if ($urandom_range(3) == 0) begin
			if (block_cols > 0 && block_rows > 0 && $urandom_range(9) < 7)
				address = $urandom_range(block_rows - 1) * cols
					+ $urandom_range(block_cols - 1);
			else
				address = $urandom_range(bra_pkg::STORE_DEPTH - 1);
			return make_write(address, $urandom());
		end
		for (int tries = 0; tries < 20; tries++) begin
			b = make_query(pick_coord(block_cols, cols), pick_coord(block_rows, rows),
				pick_coord(block_cols, cols), pick_coord(block_rows, rows));
			if (board.rect_written(b))
				return b;
		end
		// fall back to a rectangle right of the frame, which reads nothing
		return make_query(bra_pkg::COORD_W'(cols + $urandom_range(500)),
			bra_pkg::COORD_W'($urandom()),
			bra_pkg::COORD_W'(cols + $urandom_range(500)),
			bra_pkg::COORD_W'($urandom()));
	endfunction

	// Offer one beat after a random gap and hold it until accepted
	task automatic send_beat(beat_t b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		mode          <= b.mode;
		pixel_address <= b.address;
		pixel_red     <= b.red;
		pixel_green   <= b.green;
		pixel_blue    <= b.blue;
		pixel_alpha   <= b.alpha;
		corner_x0     <= b.x0;
		corner_y0     <= b.y0;
		corner_x1     <= b.x1;
		corner_y1     <= b.y1;
		do @(posedge clk); while (in_stall);
		board.note_input(b);
	endtask

	// Drop valid and wait until every pending average has arrived
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending_averages.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic index, logic [bra_pkg::FRAME_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		board.set_register(index, value);
	endtask

	task automatic set_frame(logic [bra_pkg::FRAME_W-1:0] width_value,
			logic [bra_pkg::FRAME_W-1:0] height_value);
		write_register(bra_pkg::CFG_FRAME_WIDTH, width_value);
		write_register(bra_pkg::CFG_FRAME_HEIGHT, height_value);
		cfg_valid <= 1'b0;
		frame_settings++;
	endtask

	task automatic set_pacing(pacing_t pacing);
		idle_pct = (pacing == PACE_SENDER) ? 57 : (pacing == PACE_BOTH) ? 28 : 0;
		stall_pct <= (pacing == PACE_RECEIVER) ? 57 : (pacing == PACE_BOTH) ? 28 : 0;
	endtask

	// New frame setting: load the corner block, then random writes and queries
	task automatic run_phase(int width_value, int height_value, pacing_t pacing,
			int random_items, bit long_hold);
		int cols, rows;
		settle();
		set_frame(width_value, height_value);
		set_pacing(pacing);
		cols       = board.frame_cols();
		rows       = board.frame_rows();
		block_cols = (cols < BLOCK_MAX) ? cols : BLOCK_MAX;
		block_rows = (rows < BLOCK_MAX) ? rows : BLOCK_MAX;
		for (int y = 0; y < block_rows; y++)
			for (int x = 0; x < block_cols; x++)
				send_beat(make_write(y * cols + x, $urandom()));
		if (long_hold)
			hold_kicks <= hold_kicks + 1;
		repeat (random_items)
			send_beat(random_item());
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load a few pixels near the corners of the reset 128 x 128 frame
		send_beat(make_write(0, '1));
		send_beat(make_write(1, '0));
		send_beat(make_write(2, $urandom()));
		send_beat(make_write(bra_pkg::MAX_WIDTH, $urandom()));
		send_beat(make_write(bra_pkg::MAX_WIDTH + 1, '1));
		send_beat(make_write(bra_pkg::MAX_WIDTH + 2, $urandom()));
		send_beat(make_write(bra_pkg::MAX_WIDTH - 2, $urandom()));
		send_beat(make_write(bra_pkg::MAX_WIDTH - 1, '0));
		send_beat(make_write(bra_pkg::STORE_DEPTH - 1, '1));

		// Single pixel, reversed corners, clamping on the left, top and right sides
		send_beat(make_query(0, 0, 0, 0));
		send_beat(make_query(2, 1, 0, 0));
		send_beat(make_query(-32768, -32768, 2, 1));
		send_beat(make_query(bra_pkg::MAX_WIDTH - 2, 0, 32767, -1));
		send_beat(make_query(bra_pkg::MAX_WIDTH - 1, bra_pkg::MAX_HEIGHT - 1,
			bra_pkg::MAX_WIDTH - 1, bra_pkg::MAX_HEIGHT - 1));

		// Rectangles wholly outside the frame
		send_beat(make_query(-32768, 0, -1, 5));
		send_beat(make_query(bra_pkg::MAX_WIDTH, 0, 32767, 0));
		send_beat(make_query(0, -32768, 2, -1));
		send_beat(make_query(0, 32767, 0, bra_pkg::MAX_HEIGHT));

		run_phase(1, 1, PACE_NONE, 5, 1'b0);
		run_phase(255, 200, PACE_SENDER, 10, 1'b1);
		run_phase(0, 7, PACE_RECEIVER, 4, 1'b0);
		run_phase(3, 4, PACE_BOTH, 5, 1'b0);
		run_phase(128, 128, PACE_NONE, 5, 1'b0);
		run_phase(6, 0, PACE_SENDER, 4, 1'b0);
		run_phase(4, 128, PACE_RECEIVER, 5, 1'b0);
		run_phase(127, 2, PACE_BOTH, 5, 1'b0);
		settle();

		$display("covered %0d pixel writes and %0d rectangle queries over %0d frame settings",
			board.writes, board.queries, frame_settings);
		$display("checked %0d averages, %0d mismatches, %0d still pending",
			board.results, board.errors, board.pending_averages.size());
		if (board.errors == 0 && board.pending_averages.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ files.f @@
sv/bra_pkg.sv
sv/bra_pixel_ram.sv
sv/bra_divider.sv
sv/box_region_average.sv
tb/tb_top.sv
